// File: sv/edbd_pkg.sv
package edbd_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int IDX_W = 16;
  localparam int DEF_TABLE_DEPTH = 65536;

  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'd127;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  localparam logic REG_MODE        = 1'b0;
  localparam logic REG_PLACEHOLDER = 1'b1;

  typedef struct packed {
    logic [1:0]        cnt;
    logic [CODE_W-1:0] c0;
    logic [CODE_W-1:0] c1;
    logic              tbl;
    logic              has;
    logic              done;
    logic              stopped;
  } res_t;

  function automatic logic [5:0] digit_value(input logic [BYTE_W-1:0] b);
    logic [5:0] v;
    v = 6'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 6'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      v = 6'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h5A) begin
      v = 6'(b - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

// File: sv/edbd_if.sv
interface edbd_in_if import edbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] byte_value;
  logic              end_of_buffer;
  logic [IDX_W-1:0]  table_index;
  logic [CODE_W-1:0] table_value;

  modport source (output valid, operation, byte_value, end_of_buffer, table_index,
                  table_value, input ready);
  modport sink (input valid, operation, byte_value, end_of_buffer, table_index,
                table_value, output ready);
endinterface

interface edbd_out_if import edbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_unit;
  logic              has_code;
  logic              text_done;
  logic              stopped_early;
  logic              last_of_run;

  modport source (output valid, code_unit, has_code, text_done, stopped_early,
                  last_of_run, input ready);
  modport sink (input valid, code_unit, has_code, text_done, stopped_early,
                last_of_run, output ready);
endinterface

// File: sv/edbd_parse.sv
module edbd_parse import edbd_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [BYTE_W-1:0]      byte_i,
  input  logic                   end_i,
  input  logic                   dbm_i,
  input  logic [CODE_W-1:0]      placeholder_i,
  input  logic                   take_i,
  output logic                   ready_o,
  output logic                   s1_valid_o,
  output res_t                   s1_res_o,
  output logic [IDX_W-1:0]       x_o,
  output logic [IDX_W-$clog2(TABLE_DEPTH):0] q_o
);

  localparam int QW = IDX_W + 1 - $clog2(TABLE_DEPTH);
  localparam int RECIP = (1 << IDX_W) / TABLE_DEPTH;

  localparam logic [2:0] PH_NORMAL  = 3'd0;
  localparam logic [2:0] PH_ESCAPE  = 3'd1;
  localparam logic [2:0] PH_HEX     = 3'd2;
  localparam logic [2:0] PH_BRACKET = 3'd3;
  localparam logic [2:0] PH_PAIR    = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [CODE_W-1:0] acc_q, acc_d;
  logic [1:0]        dcnt_q, dcnt_d;
  logic [BYTE_W-1:0] lead_q, lead_d;

  logic              s1_valid_q;
  res_t              s1_res_q, res_d;
  logic [IDX_W-1:0]  x_q, x_d;
  logic [QW-1:0]     q_q, q_d;
  logic [IDX_W+QW-1:0] prod;

  always_comb begin
    logic [CODE_W-1:0] acc_h;
    logic [1:0]        n;
    acc_h   = {acc_q[CODE_W-5:0], 4'b0000} | {10'd0, digit_value(byte_i)};
    n       = 2'd0;
    res_d   = '0;
    phase_d = phase_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    lead_d  = lead_q;
    case (phase_q)
      PH_ESCAPE: begin
        if (byte_i == CH_COLON) begin
          phase_d = PH_HEX;
          acc_d   = '0;
          dcnt_d  = '0;
        end else if (byte_i == CH_LBRACK) begin
          phase_d = PH_BRACKET;
        end else begin
          res_d.c0 = {8'd0, CH_BSLASH};
          res_d.c1 = {8'd0, byte_i};
          n        = 2'd2;
          phase_d  = PH_NORMAL;
        end
      end
      PH_HEX: begin
        if (dcnt_q == 2'd3) begin
          res_d.c0 = acc_h;
          n        = 2'd1;
          acc_d    = '0;
          dcnt_d   = '0;
          phase_d  = PH_NORMAL;
        end else begin
          acc_d  = acc_h;
          dcnt_d = dcnt_q + 2'd1;
        end
      end
      PH_BRACKET: begin
        if (byte_i == CH_RBRACK) begin
          res_d.c0 = placeholder_i;
          n        = 2'd1;
          phase_d  = PH_NORMAL;
        end
      end
      PH_PAIR: begin
        res_d.tbl = 1'b1;
        n         = 2'd1;
        phase_d   = PH_NORMAL;
      end
      default: begin
        phase_d = PH_NORMAL;
        if (byte_i == CH_BSLASH) begin
          phase_d = PH_ESCAPE;
        end else if (dbm_i && byte_i > ASCII_MAX) begin
          lead_d  = byte_i;
          phase_d = PH_PAIR;
        end else begin
          res_d.c0 = {8'd0, byte_i};
          n        = 2'd1;
        end
      end
    endcase
    res_d.has = 1'b1;
    if (end_i) begin
      if (phase_d == PH_ESCAPE && dbm_i) begin
        res_d.c0 = {8'd0, CH_BSLASH};
        n        = 2'd1;
      end else if (phase_d != PH_NORMAL) begin
        res_d.stopped = 1'b1;
      end
      if (n == 2'd0) begin
        n         = 2'd1;
        res_d.has = 1'b0;
      end
      res_d.done = 1'b1;
      phase_d    = PH_NORMAL;
      acc_d      = '0;
      dcnt_d     = '0;
      lead_d     = '0;
    end
    res_d.cnt = n;
  end

  assign x_d  = {lead_q, byte_i};
  assign prod = {{QW{1'b0}}, x_d} * (IDX_W+QW)'(RECIP);
  assign q_d  = prod[IDX_W+QW-1:IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      acc_q   <= '0;
      dcnt_q  <= '0;
      lead_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      lead_q  <= lead_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_i && res_d.cnt != 2'd0) begin
      s1_valid_q <= 1'b1;
    end else if (take_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_res_q <= res_d;
      x_q      <= x_d;
      q_q      <= q_d;
    end
  end

  assign ready_o    = !s1_valid_q || take_i;
  assign s1_valid_o = s1_valid_q;
  assign s1_res_o   = s1_res_q;
  assign x_o        = x_q;
  assign q_o        = q_q;

endmodule

// File: sv/edbd_table.sv
module edbd_table import edbd_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   waddr_i,
  input  logic [CODE_W-1:0]                wdata_i,
  input  logic                             rd_en_i,
  input  logic [IDX_W-1:0]                 x_i,
  input  logic [IDX_W-$clog2(TABLE_DEPTH):0] q_i,
  output logic [CODE_W-1:0]                rd_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = IDX_W + 1 - AW;
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W+1)'(TABLE_DEPTH);

  logic [CODE_W-1:0] mem [TABLE_DEPTH];
  logic [CODE_W-1:0] rd_q;
  logic [IDX_W:0]    qd;
  logic [IDX_W:0]    rem0;
  logic [IDX_W:0]    rem1;
  logic [AW-1:0]     raddr;

  assign qd    = {{(IDX_W+1-QW){1'b0}}, q_i} * DEPTH_C;
  assign rem0  = {1'b0, x_i} - qd;
  assign rem1  = (rem0 >= DEPTH_C) ? rem0 - DEPTH_C : rem0;
  assign raddr = rem1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: sv/edbd_emit.sv
module edbd_emit import edbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_valid_i,
  input  res_t              s1_res_i,
  input  logic [CODE_W-1:0] rd_data_i,
  output logic              take_o,
  edbd_out_if.source        out_o
);

  logic              s2_valid_q;
  res_t              s2_res_q;
  logic              sel_q;
  logic              out_valid_q;
  logic [CODE_W-1:0] code_q;
  logic              has_q;
  logic              done_q;
  logic              stopped_q;
  logic              last_q;

  logic              out_free;
  logic              emit;
  logic              is_last;
  logic              s2_free;
  logic [CODE_W-1:0] code_sel;

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = s2_valid_q && out_free;
  assign is_last  = (s2_res_q.cnt == 2'd2) ? sel_q : !sel_q;
  assign s2_free  = !s2_valid_q || (emit && is_last);
  assign take_o   = s1_valid_i && s2_free;
  assign code_sel = sel_q ? s2_res_q.c1 : (s2_res_q.tbl ? rd_data_i : s2_res_q.c0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      sel_q      <= 1'b0;
    end else if (take_o) begin
      s2_valid_q <= 1'b1;
      sel_q      <= 1'b0;
    end else if (emit && is_last) begin
      s2_valid_q <= 1'b0;
    end else if (emit) begin
      sel_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      s2_res_q <= s1_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      code_q    <= code_sel;
      has_q     <= s2_res_q.has;
      done_q    <= s2_res_q.done && is_last;
      stopped_q <= s2_res_q.stopped && is_last;
      last_q    <= is_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_unit     = code_q;
  assign out_o.has_code      = has_q;
  assign out_o.text_done     = done_q;
  assign out_o.stopped_early = stopped_q;
  assign out_o.last_of_run   = last_q;

`ifndef ASSERT_OFF
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready && !last_q |=> out_valid_q)
    else $error("Second result of an item did not follow.");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q)
    else $error("Final result of a buffer not marked last.");

  a_stop_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stopped_q |-> done_q && !has_q && code_q == '0)
    else $error("Early stop carries a code unit.");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && sel_q |-> s2_res_q.cnt == 2'd2)
    else $error("Result select beyond result count.");
`endif

endmodule

// File: sv/escape_and_double_byte_decoder.sv
// Decodes a byte stream into 16-bit code units at one input item per clock cycle while the
// input is ready; back-pressure on the output stalls the input. Each data item passes
// through the parser, then a stage that reads the code table, then the output register. An
// item that gives two results holds the input back, because the output delivers one result
// per cycle while it is not stalled. Table writes are taken at the full rate while the input
// is ready and produce no result. The code table is one synchronous memory with a single
// write and a single read port; it has no reset and needs no clearing pass.
module escape_and_double_byte_decoder import edbd_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edbd_in_if.sink     in_i,
  edbd_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = IDX_W + 1 - AW;
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W+1)'(TABLE_DEPTH);

  logic              dbm_q;
  logic [CODE_W-1:0] placeholder_q;
  logic              cfg_wr;

  logic              in_acc;
  logic              data_acc;
  logic              tbl_we;
  logic              take;
  logic              s1_valid;
  res_t              s1_res;
  logic [IDX_W-1:0]  x;
  logic [QW-1:0]     q;
  logic [CODE_W-1:0] rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbm_q         <= 1'b0;
      placeholder_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        dbm_q <= pwdata[0];
      end else begin
        placeholder_q <= pwdata[CODE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PLACEHOLDER) ? {16'd0, placeholder_q} : {31'd0, dbm_q};

  assign in_acc   = in_i.valid && in_i.ready;
  assign data_acc = in_acc && (in_i.operation == OP_DATA);
  assign tbl_we   = in_acc && (in_i.operation == OP_TABLE) &&
                    ({1'b0, in_i.table_index} < DEPTH_C);

  edbd_parse #(.TABLE_DEPTH(TABLE_DEPTH)) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (data_acc),
    .byte_i        (in_i.byte_value),
    .end_i         (in_i.end_of_buffer),
    .dbm_i         (dbm_q),
    .placeholder_i (placeholder_q),
    .take_i        (take),
    .ready_o       (in_i.ready),
    .s1_valid_o    (s1_valid),
    .s1_res_o      (s1_res),
    .x_o           (x),
    .q_o           (q)
  );

  edbd_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (in_i.table_index[AW-1:0]),
    .wdata_i   (in_i.table_value),
    .rd_en_i   (take),
    .x_i       (x),
    .q_i       (q),
    .rd_data_o (rd_data)
  );

  edbd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_res_i   (s1_res),
    .rd_data_i  (rd_data),
    .take_o     (take),
    .out_o      (out_o)
  );

endmodule
